// ===== rtl/b85_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the character reverse lookup for the base85 decoder.
// Depends on nothing; every other file imports it.
package b85_pkg;

    // Radix of one digit and the largest legal group value.
    localparam logic [6:0]  RADIX      = 7'd85;
    localparam logic [31:0] GROUP_MAX  = 32'hFFFF_FFFF;
    localparam logic [2:0]  LAST_DIGIT = 3'd4;
    localparam logic [2:0]  WORD_BYTES = 3'd4;

    // Queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Result status codes.
    typedef enum logic [1:0] {
        ST_BYTE     = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // Outcome of looking up one character.
    typedef struct packed {
        logic       valid;
        logic [6:0] value;
    } t_digit;

    // One unit of work for the back: a word and how many results it yields.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;
        t_status     status;
        logic        msg_end;
    } t_job;

    // Reverse alphabet lookup: digits, upper case, lower case, then symbols.
    function automatic t_digit digit_of(input logic [7:0] c);
        t_digit r;
        r.valid = 1'b1;
        r.value = 7'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 7'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            r.value = 7'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.value = 7'(c - 8'h61 + 8'd36);
        end else begin
            unique case (c)
                8'h21: r.value = 7'd62;
                8'h23: r.value = 7'd63;
                8'h24: r.value = 7'd64;
                8'h25: r.value = 7'd65;
                8'h26: r.value = 7'd66;
                8'h28: r.value = 7'd67;
                8'h29: r.value = 7'd68;
                8'h2A: r.value = 7'd69;
                8'h2B: r.value = 7'd70;
                8'h2D: r.value = 7'd71;
                8'h3B: r.value = 7'd72;
                8'h3C: r.value = 7'd73;
                8'h3D: r.value = 7'd74;
                8'h3E: r.value = 7'd75;
                8'h3F: r.value = 7'd76;
                8'h40: r.value = 7'd77;
                8'h5E: r.value = 7'd78;
                8'h5F: r.value = 7'd79;
                8'h60: r.value = 7'd80;
                8'h7B: r.value = 7'd81;
                8'h7C: r.value = 7'd82;
                8'h7D: r.value = 7'd83;
                8'h7E: r.value = 7'd84;
                default: r.valid = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

// ===== rtl/b85_front.sv =====
`timescale 1ns / 1ps
// Front of the decoder: accepts characters, accumulates groups, tracks the byte count.
// Depends on b85_pkg; pushes one job per finished group or error into the queue.
module b85_front #(
    parameter int COUNT_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_char_code,
    input  logic          i_starts_message,
    input  logic [15:0]   i_message_bytes,
    input  logic          i_q_full,
    output logic          o_push,
    output b85_pkg::t_job o_job
);
    import b85_pkg::*;

    logic [31:0]           r_group, n_group;
    logic [2:0]            r_pos, n_pos;
    logic [COUNT_BITS-1:0] r_left, n_left;
    logic                  r_aborted, n_aborted;

    logic                  accept;
    logic [31:0]           eff_group;
    logic [2:0]            eff_pos;
    logic [COUNT_BITS-1:0] eff_left;
    logic                  eff_aborted;
    logic                  active;
    t_digit                dig;
    logic [38:0]           full;
    logic [2:0]            cnt;

    // The queue never overflows: a character is taken only while it has room.
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // A message start clears the group and reloads the count before decoding.
    always_comb begin
        eff_group   = i_starts_message ? 32'd0 : r_group;
        eff_pos     = i_starts_message ? 3'd0 : r_pos;
        eff_left    = i_starts_message ? COUNT_BITS'(i_message_bytes) : r_left;
        eff_aborted = i_starts_message ? 1'b0 : r_aborted;
        active      = !eff_aborted && (eff_left != '0);
        dig         = digit_of(i_char_code);
        full        = 39'(eff_group) * 39'(RADIX) + 39'(dig.value);
        cnt         = (eff_left < COUNT_BITS'(WORD_BYTES)) ? 3'(eff_left) : WORD_BYTES;
    end

    // Next state and the job that this character causes, if any.
    always_comb begin
        n_group       = r_group;
        n_pos         = r_pos;
        n_left        = r_left;
        n_aborted     = r_aborted;
        o_push        = 1'b0;
        o_job.word    = 32'd0;
        o_job.cnt     = 3'd1;
        o_job.status  = ST_BYTE;
        o_job.msg_end = 1'b1;
        if (accept) begin
            n_group   = eff_group;
            n_pos     = eff_pos;
            n_left    = eff_left;
            n_aborted = eff_aborted;
            if (active) begin
                if (!dig.valid) begin
                    n_aborted    = 1'b1;
                    n_group      = 32'd0;
                    n_pos        = 3'd0;
                    o_push       = 1'b1;
                    o_job.status = ST_BAD_CHAR;
                end else if (eff_pos < LAST_DIGIT) begin
                    n_group = full[31:0];
                    n_pos   = eff_pos + 3'd1;
                end else begin
                    n_group = 32'd0;
                    n_pos   = 3'd0;
                    o_push  = 1'b1;
                    if (full > 39'(GROUP_MAX)) begin
                        n_aborted    = 1'b1;
                        o_job.status = ST_OVERFLOW;
                    end else begin
                        n_left        = eff_left - COUNT_BITS'(cnt);
                        o_job.word    = full[31:0];
                        o_job.cnt     = cnt;
                        o_job.msg_end = (eff_left == COUNT_BITS'(cnt));
                    end
                end
            end
        end
    end

    // Decoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group   <= 32'd0;
            r_pos     <= 3'd0;
            r_left    <= '0;
            r_aborted <= 1'b0;
        end else begin
            r_group   <= n_group;
            r_pos     <= n_pos;
            r_left    <= n_left;
            r_aborted <= n_aborted;
        end
    end

    // A pushed byte job always asks for between one and four results.
    a_job_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_job.cnt != 3'd0 && o_job.cnt <= WORD_BYTES))
        else $error("front pushed a job with a bad result count");

endmodule

// ===== rtl/b85_queue.sv =====
`timescale 1ns / 1ps
// Short job queue that decouples the front from the back.
// Depends on b85_pkg for the job type and the queue depth.
module b85_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  b85_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output b85_pkg::t_job o_job
);
    import b85_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic            do_pop;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Job storage holds no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_count <= r_count + Q_CW'(i_push) - Q_CW'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("job popped from an empty queue");

endmodule

// ===== rtl/b85_back.sv =====
`timescale 1ns / 1ps
// Back of the decoder: splits each job into result items, one per cycle while not stalled.
// Depends on b85_pkg; reads jobs from the queue and drives the output register.
module b85_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  b85_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_data_byte,
    output logic [1:0]    o_status,
    output logic          o_group_end,
    output logic          o_message_end
);
    import b85_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_data;
    t_status    r_status;
    logic       r_ge, r_me;

    logic       load;
    logic       last;
    logic [7:0] sel_byte;

    // The output register takes a new item whenever it is empty or being taken.
    assign load  = i_q_valid && (!r_valid || i_ready);
    assign last  = (3'(r_idx) + 3'd1 == i_job.cnt);
    assign o_pop = load && last;

    // Bytes leave most significant first.
    always_comb begin
        unique case (r_idx)
            2'd0: sel_byte = i_job.word[31:24];
            2'd1: sel_byte = i_job.word[23:16];
            2'd2: sel_byte = i_job.word[15:8];
            2'd3: sel_byte = i_job.word[7:0];
        endcase
    end

    // Byte index within the current job and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= last ? 2'd0 : r_idx + 2'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data   <= sel_byte;
            r_status <= i_job.status;
            r_ge     <= last;
            r_me     <= last && i_job.msg_end;
        end
    end

    assign o_valid       = r_valid;
    assign o_data_byte   = r_data;
    assign o_status      = r_status;
    assign o_group_end   = r_ge;
    assign o_message_end = r_me;

    // An error item closes both its group and its message.
    a_err_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != ST_BYTE) |-> (r_ge && r_me))
        else $error("error item without group and message end");

    // The byte index never runs past the job being split.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (3'(r_idx) < i_job.cnt))
        else $error("byte index beyond job result count");

endmodule

// ===== rtl/base85_decoder_top.sv =====
`timescale 1ns / 1ps
// Top level of the streaming base85 decoder.
// Depends on b85_pkg, b85_front, b85_queue and b85_back.
//
//  Channel  Direction  Handshake           Payload
//  input    in         i_valid / o_ready   i_char_code, i_starts_message, i_message_bytes
//  output   out        o_valid / i_ready   o_data_byte, o_status, o_group_end, o_message_end
//
// One character is accepted per cycle while the job queue has room; a character that
// completes a group pushes its job when accepted; the back loads its first item into the
// output register once the job heads the queue and the register is empty or being taken.
// Each group yields at most four items, one per cycle from the back while not stalled, so
// five characters per group keep both sides at full rate; the four-entry queue absorbs
// output stalls. Reset is synchronous, active low, and needs no clearing pass.
module base85_decoder_top #(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_starts_message,
    input  logic [15:0] i_message_bytes,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_data_byte,
    output logic [1:0]  o_status,
    output logic        o_group_end,
    output logic        o_message_end
);
    import b85_pkg::*;

    logic q_full, q_push, q_pop, q_valid;
    t_job push_job, head_job;

    b85_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_char_code      (i_char_code),
        .i_starts_message (i_starts_message),
        .i_message_bytes  (i_message_bytes),
        .i_q_full         (q_full),
        .o_push           (q_push),
        .o_job            (push_job)
    );

    b85_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    b85_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_job         (head_job),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_data_byte   (o_data_byte),
        .o_status      (o_status),
        .o_group_end   (o_group_end),
        .o_message_end (o_message_end)
    );

endmodule
